// ===== rtl/core/hdlf_pkg.sv =====
// Package for the hex dump line formatter.
// Holds the shared item descriptor type, register index codes and the hex digit helper.
// Used by all modules in rtl/core; depends on nothing.
package hdlf_pkg;

    // Configuration register index codes.
    localparam logic [2:0] REG_BYTES_PER_LINE   = 3'd0;
    localparam logic [2:0] REG_PREFIX_CHARS     = 3'd1;
    localparam logic [2:0] REG_PREFIX_LENGTH    = 3'd2;
    localparam logic [2:0] REG_DELIMITER_CHARS  = 3'd3;
    localparam logic [2:0] REG_DELIMITER_LENGTH = 3'd4;

    // Fixed character constants.
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Descriptor queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Classified input byte, as handed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data;
        logic       is_final;
        logic       line_break;
        logic [3:0] tail_count;   // characters after the two hex digits
    } item_desc_t;

    // Upper-case ASCII hex digit for one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] ch;
        if (nibble < 4'd10)
        begin
            ch = 8'h30 + {4'd0, nibble};
        end
        else
        begin
            ch = 8'h37 + {4'd0, nibble};
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/hdlf_front.sv =====
// Front part of the hex dump line formatter: accepts byte transactions,
// keeps the line position and classifies each byte as line break or delimiter.
// Depends on hdlf_pkg.
module hdlf_front #(
    parameter int PREFIX_MAX    = 8,
    parameter int DELIMITER_MAX = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_valid,
    output logic                     byte_stall,
    input  logic [7:0]               data_byte,
    input  logic                     final_byte,
    input  logic [15:0]              bytes_per_line,
    input  logic [3:0]               prefix_length,
    input  logic [2:0]               delim_len,
    input  logic                     queue_full,
    output logic                     push,
    output hdlf_pkg::item_desc_t     push_desc
);

    logic [15:0] line_position_reg;
    logic [15:0] line_position_next;
    logic [15:0] next_position;
    logic        line_break;
    logic [3:0]  prefix_count;
    logic [3:0]  delimiter_count;

    // Accept whenever the queue has room.
    assign byte_stall = queue_full;
    assign push       = byte_valid && !queue_full;

    // Line break decision; zero bytes per line means a break on counter wrap.
    assign next_position = line_position_reg + 16'd1;
    always_comb
    begin
        if (bytes_per_line == 16'd0)
        begin
            line_break = (next_position == 16'd0);
        end
        else
        begin
            line_break = (next_position >= bytes_per_line);
        end
    end

    // Saturate the configured lengths to their maxima.
    always_comb
    begin
        if (prefix_length > 4'(PREFIX_MAX))
        begin
            prefix_count = 4'(PREFIX_MAX);
        end
        else
        begin
            prefix_count = prefix_length;
        end
        if ({1'b0, delim_len} > 4'(DELIMITER_MAX))
        begin
            delimiter_count = 4'(DELIMITER_MAX);
        end
        else
        begin
            delimiter_count = {1'b0, delim_len};
        end
    end

    // Build the descriptor for the back part.
    always_comb
    begin
        push_desc.data       = data_byte;
        push_desc.is_final   = final_byte;
        push_desc.line_break = line_break && !final_byte;
        if (final_byte)
        begin
            push_desc.tail_count = 4'd0;
        end
        else if (line_break)
        begin
            push_desc.tail_count = prefix_count + 4'd1;
        end
        else
        begin
            push_desc.tail_count = delimiter_count;
        end
    end

    // Line position update on each accepted transaction.
    always_comb
    begin
        line_position_next = line_position_reg;
        if (push)
        begin
            if (final_byte || line_break)
            begin
                line_position_next = 16'd0;
            end
            else
            begin
                line_position_next = next_position;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_position_reg <= 16'd0;
        end
        else
        begin
            line_position_reg <= line_position_next;
        end
    end

endmodule

// ===== rtl/core/hdlf_queue.sv =====
// Short descriptor queue between the front and back parts of the formatter.
// Register based FIFO of hdlf_pkg::item_desc_t entries.
// Depends on hdlf_pkg.
module hdlf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hdlf_pkg::item_desc_t  push_desc,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output hdlf_pkg::item_desc_t  head_desc
);

    localparam int DEPTH = hdlf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = hdlf_pkg::QUEUE_PTR_W;
    localparam int CNT_W = hdlf_pkg::QUEUE_CNT_W;

    hdlf_pkg::item_desc_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== rtl/core/hdlf_back.sv =====
// Back part of the hex dump line formatter: expands one queued descriptor
// into characters through a registered output stage, one per cycle while
// char_stall is low. Depends on hdlf_pkg.
module hdlf_back #(
    parameter int PREFIX_BYTES    = 8,
    parameter int DELIMITER_BYTES = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  hdlf_pkg::item_desc_t         head_desc,
    output logic                         pop,
    input  logic [8*PREFIX_BYTES-1:0]    prefix_chars,
    input  logic [8*DELIMITER_BYTES-1:0] delimiter_chars,
    output logic                         char_valid,
    input  logic                         char_stall,
    output logic [7:0]                   text_char,
    output logic                         run_end,
    output logic                         message_end
);

    logic [3:0] char_idx_reg;
    logic [3:0] char_idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] text_char_reg;
    logic       run_end_reg;
    logic       message_end_reg;
    logic       load;
    logic       last_char;
    logic [3:0] tail_idx;
    logic [3:0] prefix_idx;
    logic [7:0] prefix_byte;
    logic [7:0] delimiter_byte;
    logic [7:0] char_sel;

    // Output stage loads from a valid queue head whenever it is empty or being drained.
    assign load      = head_valid && (!out_valid_reg || !char_stall);
    assign last_char = (char_idx_reg == (head_desc.tail_count + 4'd1));
    assign pop       = load && last_char;

    assign tail_idx   = char_idx_reg - 4'd2;
    assign prefix_idx = char_idx_reg - 4'd3;

    // Prefix and delimiter character lookup.
    always_comb
    begin
        prefix_byte    = 8'd0;
        delimiter_byte = 8'd0;
        for (int k = 0; k < PREFIX_BYTES; k++)
        begin
            if (prefix_idx == 4'(k))
            begin
                prefix_byte = prefix_chars[8*k +: 8];
            end
        end
        for (int k = 0; k < DELIMITER_BYTES; k++)
        begin
            if (tail_idx == 4'(k))
            begin
                delimiter_byte = delimiter_chars[8*k +: 8];
            end
        end
    end

    // Character selection by position within the run.
    always_comb
    begin
        if (char_idx_reg == 4'd0)
        begin
            char_sel = hdlf_pkg::hex_char(head_desc.data[7:4]);
        end
        else if (char_idx_reg == 4'd1)
        begin
            char_sel = hdlf_pkg::hex_char(head_desc.data[3:0]);
        end
        else if (head_desc.line_break)
        begin
            char_sel = (char_idx_reg == 4'd2) ? hdlf_pkg::CHAR_NEWLINE : prefix_byte;
        end
        else
        begin
            char_sel = delimiter_byte;
        end
    end

    // Character counter and output valid.
    always_comb
    begin
        char_idx_next  = char_idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            char_idx_next  = last_char ? 4'd0 : char_idx_reg + 4'd1;
            out_valid_next = 1'b1;
        end
        else if (!char_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_idx_reg  <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            char_idx_reg  <= char_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            text_char_reg   <= char_sel;
            run_end_reg     <= last_char;
            message_end_reg <= head_desc.is_final && (char_idx_reg == 4'd1);
        end
    end

    assign char_valid  = out_valid_reg;
    assign text_char   = text_char_reg;
    assign run_end     = run_end_reg;
    assign message_end = message_end_reg;

endmodule

// ===== rtl/core/hex_dump_line_formatter.sv =====
// Hex dump line formatter. Each accepted byte transaction produces two upper-case hex
// characters, then either a newline plus the line prefix (when the byte fills a line),
// the delimiter, or nothing for the final byte of a message; run_end marks the last
// character of each byte and message_end the last character of the message. The output
// carries one character per cycle while char_stall is low. A byte gives 2 characters
// when final, 2 + delimiter length within a line and 3 + prefix_length at a line break
// (lengths saturated to DELIMITER_MAX and PREFIX_MAX). A byte transaction is taken in
// any cycle in which the two-entry descriptor queue has room, independent of output
// stalls. The user must write configuration registers only while the block is idle; the
// block does not enforce it. Depends on hdlf_pkg, hdlf_front, hdlf_queue and hdlf_back.
module hex_dump_line_formatter #(
    parameter int PREFIX_MAX    = 8,
    parameter int DELIMITER_MAX = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        char_valid,
    input  logic        char_stall,
    output logic [7:0]  text_char,
    output logic        run_end,
    output logic        message_end
);

    // Only delimiter characters that can be emitted and that exist are stored.
    localparam int DELIMITER_BYTES = (DELIMITER_MAX < 4) ? DELIMITER_MAX : 4;
    localparam int PREFIX_BITS     = 8 * PREFIX_MAX;
    localparam int DELIMITER_BITS  = 8 * DELIMITER_BYTES;

    logic [15:0]               bytes_per_line_reg;
    logic [PREFIX_BITS-1:0]    prefix_chars_reg;
    logic [3:0]                prefix_length_reg;
    logic [DELIMITER_BITS-1:0] delimiter_chars_reg;
    logic [2:0]                delim_len_reg;

    logic                      push;
    hdlf_pkg::item_desc_t      push_desc;
    logic                      queue_full;
    logic                      pop;
    logic                      head_valid;
    hdlf_pkg::item_desc_t      head_desc;

    // Configuration registers; unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_per_line_reg   <= 16'd16;
            prefix_chars_reg     <= '0;
            prefix_length_reg    <= 4'd0;
            delimiter_chars_reg  <= DELIMITER_BITS'(32'h20);
            delim_len_reg        <= 3'd1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                hdlf_pkg::REG_BYTES_PER_LINE:
                begin
                    bytes_per_line_reg <= cfg_data[15:0];
                end
                hdlf_pkg::REG_PREFIX_CHARS:
                begin
                    prefix_chars_reg <= cfg_data[PREFIX_BITS-1:0];
                end
                hdlf_pkg::REG_PREFIX_LENGTH:
                begin
                    prefix_length_reg <= cfg_data[3:0];
                end
                hdlf_pkg::REG_DELIMITER_CHARS:
                begin
                    delimiter_chars_reg <= cfg_data[DELIMITER_BITS-1:0];
                end
                hdlf_pkg::REG_DELIMITER_LENGTH:
                begin
                    delim_len_reg <= cfg_data[2:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Front part: accept and classify.
    hdlf_front #(
        .PREFIX_MAX    (PREFIX_MAX),
        .DELIMITER_MAX (DELIMITER_MAX)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_valid       (byte_valid),
        .byte_stall       (byte_stall),
        .data_byte        (data_byte),
        .final_byte       (final_byte),
        .bytes_per_line   (bytes_per_line_reg),
        .prefix_length    (prefix_length_reg),
        .delim_len        (delim_len_reg),
        .queue_full       (queue_full),
        .push             (push),
        .push_desc        (push_desc)
    );

    // Descriptor queue.
    hdlf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    // Back part: character generation.
    hdlf_back #(
        .PREFIX_BYTES    (PREFIX_MAX),
        .DELIMITER_BYTES (DELIMITER_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_desc       (head_desc),
        .pop             (pop),
        .prefix_chars    (prefix_chars_reg),
        .delimiter_chars (delimiter_chars_reg),
        .char_valid      (char_valid),
        .char_stall      (char_stall),
        .text_char       (text_char),
        .run_end         (run_end),
        .message_end     (message_end)
    );

endmodule

// ===== test/hex_dump_line_formatter_tb.sv =====
// Self-checking testbench for the hex dump line formatter.
// Drives byte transactions and register writes, predicts every output character and checks it.
// Depends on hdlf_pkg and the hex_dump_line_formatter RTL.
module hex_dump_line_formatter_tb;

    localparam int PREFIX_MAX    = 8;
    localparam int DELIMITER_MAX = 4;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 20;

    typedef struct {
        logic [7:0] data;
        logic       is_final;
    } byte_item_t;

    typedef struct {
        logic [7:0] text_char;
        logic       run_end;
        logic       message_end;
    } text_item_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [63:0] cfg_data     = '0;
    logic        byte_valid   = 1'b0;
    logic [7:0]  data_byte    = '0;
    logic        final_byte   = 1'b0;
    logic        char_stall   = 1'b0;
    logic        byte_stall;
    logic        char_valid;
    logic [7:0]  text_char;
    logic        run_end;
    logic        message_end;

    // Local copy of the formatter registers and line state.
    logic [15:0] bytes_per_line   = 16'd16;
    logic [63:0] prefix_chars     = '0;
    logic [3:0]  prefix_length    = '0;
    logic [31:0] delimiter_chars  = 32'd32;
    logic [2:0]  delim_len        = 3'd1;
    logic [15:0] line_position    = '0;

    byte_item_t pending_bytes[$];
    text_item_t expected_text[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit byte_taken    = 1'b0;
    int mismatches    = 0;
    int bytes_done    = 0;
    int chars_checked = 0;
    int messages_done = 0;
    int line_breaks   = 0;
    int reg_writes    = 0;
    int idle_cycles   = 0;

    hex_dump_line_formatter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .final_byte   (final_byte),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .text_char    (text_char),
        .run_end      (run_end),
        .message_end  (message_end)
    );

    always #5 clk = ~clk;

    // Upper-case ASCII digit for one nibble.
    function automatic logic [7:0] ascii_hex(input logic [3:0] nibble);
        if (nibble < 4'd10)
        begin
            return "0" + {4'd0, nibble};
        end
        return "A" + {4'd0, nibble} - 8'd10;
    endfunction

    function automatic void push_char(input logic [7:0] ch);
        text_item_t t;
        t.text_char   = ch;
        t.run_end     = 1'b0;
        t.message_end = 1'b0;
        expected_text.push_back(t);
    endfunction

    // Appends the characters one byte transaction produces and advances the line state.
    function automatic void predict_text(input byte_item_t item);
        logic [15:0] next_pos;
        int          count;
        push_char(ascii_hex(item.data[7:4]));
        push_char(ascii_hex(item.data[3:0]));
        if (item.is_final)
        begin
            expected_text[expected_text.size() - 1].message_end = 1'b1;
            line_position = '0;
            messages_done++;
        end
        else
        begin
            next_pos = line_position + 16'd1;
            // A zero line length means the line ends only when the counter wraps.
            if ((bytes_per_line == 16'd0) ? (next_pos == 16'd0) : (next_pos >= bytes_per_line))
            begin
                push_char(hdlf_pkg::CHAR_NEWLINE);
                count = (prefix_length > PREFIX_MAX) ? PREFIX_MAX : prefix_length;
                for (int k = 0; k < count; k++)
                begin
                    push_char(prefix_chars[8 * k +: 8]);
                end
                line_position = '0;
                line_breaks++;
            end
            else
            begin
                count = (delim_len > DELIMITER_MAX) ? DELIMITER_MAX : delim_len;
                for (int k = 0; k < count; k++)
                begin
                    push_char((k < 4) ? delimiter_chars[8 * k +: 8] : 8'd0);
                end
                line_position = next_pos;
            end
        end
        expected_text[expected_text.size() - 1].run_end = 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    // Register write; the local copy keeps only the bits the register holds.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        reg_writes++;
        case (idx)
            hdlf_pkg::REG_BYTES_PER_LINE:   bytes_per_line   = value[15:0];
            hdlf_pkg::REG_PREFIX_CHARS:     prefix_chars     = value;
            hdlf_pkg::REG_PREFIX_LENGTH:    prefix_length    = value[3:0];
            hdlf_pkg::REG_DELIMITER_CHARS:  delimiter_chars  = value[31:0];
            hdlf_pkg::REG_DELIMITER_LENGTH: delim_len        = value[2:0];
            default: ;
        endcase
    endtask

    // Writes every index past the last register with noise; none of it may take effect.
    task automatic write_unused_regs();
        for (int idx = int'(hdlf_pkg::REG_DELIMITER_LENGTH) + 1; idx < 8; idx++)
        begin
            write_reg(idx[2:0], {$urandom, $urandom});
        end
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic is_final);
        byte_item_t item;
        item.data     = data;
        item.is_final = is_final;
        pending_bytes.push_back(item);
    endtask

    task automatic queue_bytes(input int count, input bit ends);
        for (int i = 0; i < count; i++)
        begin
            queue_byte(8'($urandom_range(0, 255)), ends && (i == count - 1));
        end
    endtask

    // Blocks until every queued transaction is taken and every character has come out.
    task automatic wait_idle();
        @(posedge clk);
        while (pending_bytes.size() != 0 || byte_valid || expected_text.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random register set, with noise in the bits above each register's width.
    task automatic random_config();
        logic [63:0] value;
        value = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: value[15:0] = 16'd0;
            1: value[15:0] = 16'hFFFF;
            2: value[15:0] = 16'($urandom_range(1, 65535));
            default: value[15:0] = 16'($urandom_range(1, 8));
        endcase
        write_reg(hdlf_pkg::REG_BYTES_PER_LINE, value);
        write_reg(hdlf_pkg::REG_PREFIX_CHARS, {$urandom, $urandom});
        value = {$urandom, $urandom};
        value[3:0] = 4'($urandom_range(0, 15));
        write_reg(hdlf_pkg::REG_PREFIX_LENGTH, value);
        write_reg(hdlf_pkg::REG_DELIMITER_CHARS, {$urandom, $urandom});
        value = {$urandom, $urandom};
        value[2:0] = 3'($urandom_range(0, 7));
        write_reg(hdlf_pkg::REG_DELIMITER_LENGTH, value);
    endtask

    // Byte driver and output stall generator, both changing on the falling edge.
    always @(negedge clk)
    begin
        byte_item_t item;
        if (rst_n && (!byte_valid || byte_taken))
        begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item = pending_bytes.pop_front();
                byte_valid <= 1'b1;
                data_byte  <= item.data;
                final_byte <= item.is_final;
            end
            else
            begin
                byte_valid <= 1'b0;
            end
        end
        char_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // Monitor: predicts accepted bytes, checks accepted characters, runs the watchdog.
    always @(posedge clk)
    begin
        byte_item_t seen;
        text_item_t want;
        if (rst_n)
        begin
            byte_taken <= byte_valid && !byte_stall;
            if (byte_valid && !byte_stall)
            begin
                seen.data     = data_byte;
                seen.is_final = final_byte;
                predict_text(seen);
                bytes_done++;
            end
            if (char_valid && !char_stall)
            begin
                chars_checked++;
                if (expected_text.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character %02h", text_char));
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text_char !== want.text_char || run_end !== want.run_end ||
                        message_end !== want.message_end)
                    begin
                        report_mismatch($sformatf(
                            "char %02h run_end %b message_end %b, want %02h %b %b",
                            text_char, run_end, message_end,
                            want.text_char, want.run_end, want.message_end));
                    end
                end
            end
            if ((byte_valid && !byte_stall) || (char_valid && !char_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("Watchdog: no transaction for %0d cycles, %0d characters pending",
                             IDLE_LIMIT, expected_text.size());
                    $display("hex_dump_line_formatter regression: fail");
                    $finish;
                end
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        int queued;
        int len;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings, with no idling: digit extremes and a one-byte message.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h0F, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'hA5, 1'b0);
        queue_byte(8'h5A, 1'b0);
        queue_byte(8'h09, 1'b0);
        queue_byte(8'h0A, 1'b1);
        queue_byte(8'h3C, 1'b1);
        wait_idle();

        // One byte per line, a full prefix with zero characters, no delimiter.
        send_idle_pct = 15;
        stall_pct     = 15;
        write_reg(hdlf_pkg::REG_BYTES_PER_LINE, 64'd1);
        write_reg(hdlf_pkg::REG_PREFIX_CHARS, 64'h00FF_7E20_3E00_2D3A);
        write_reg(hdlf_pkg::REG_PREFIX_LENGTH, 64'd8);
        write_reg(hdlf_pkg::REG_DELIMITER_LENGTH, 64'd0);
        queue_bytes(4, 1'b1);
        wait_idle();

        // Over-long lengths saturate; writes to unused indexes change nothing.
        write_reg(hdlf_pkg::REG_BYTES_PER_LINE, 64'd3);
        write_reg(hdlf_pkg::REG_PREFIX_LENGTH, 64'd15);
        write_reg(hdlf_pkg::REG_DELIMITER_CHARS, 64'hFF00_2C20);
        write_reg(hdlf_pkg::REG_DELIMITER_LENGTH, 64'd7);
        write_unused_regs();
        queue_bytes(7, 1'b1);
        wait_idle();

        // Line length lowered below the current position in the middle of a message.
        write_reg(hdlf_pkg::REG_BYTES_PER_LINE, 64'hFFFF);
        queue_bytes(3, 1'b0);
        wait_idle();
        write_reg(hdlf_pkg::REG_BYTES_PER_LINE, 64'd2);
        queue_bytes(2, 1'b1);
        wait_idle();

        // Longest line settings: zero length and the largest length, short messages.
        send_idle_pct = 0;
        stall_pct     = 0;
        write_reg(hdlf_pkg::REG_DELIMITER_LENGTH, 64'd0);
        write_reg(hdlf_pkg::REG_PREFIX_LENGTH, 64'd2);
        write_reg(hdlf_pkg::REG_BYTES_PER_LINE, 64'd0);
        queue_bytes(6, 1'b1);
        wait_idle();
        write_reg(hdlf_pkg::REG_BYTES_PER_LINE, 64'hFFFF);
        queue_bytes(5, 1'b1);
        wait_idle();

        // Random messages under random settings, one idling pattern per phase.
        for (int mode = 0; mode < 4; mode++)
        begin
            send_idle_pct = (mode == 1) ? 76 : (mode == 3) ? 15 : 0;
            stall_pct     = (mode == 2) ? 76 : (mode == 3) ? 15 : 0;
            for (int sub = 0; sub < 3; sub++)
            begin
                random_config();
                queued = 0;
                while (queued < 12)
                begin
                    len = $urandom_range(1, 12);
                    // Mostly whole messages; some stop short and carry the line over.
                    queue_bytes(len, $urandom_range(0, 99) >= 15);
                    queued += len;
                end
                wait_idle();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_text.size() != 0)
        begin
            report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
        end
        $display("Covered %0d byte transactions in %0d messages: %0d characters, %0d line breaks.",
                 bytes_done, messages_done, chars_checked, line_breaks);
        $display("Used %0d register writes across directed and random phases.",
                 reg_writes);
        if (mismatches == 0)
        begin
            $display("hex_dump_line_formatter regression: pass");
        end
        else
        begin
            $display("hex_dump_line_formatter regression: fail");
        end
        $finish;
    end

endmodule
